[hdl/dpas_pkg.sv]
// ----------------------------------------------------------------------------
// Dynamic priority aging scheduler package
// Shared sizes, opcodes, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package dpas_pkg;

	localparam int MaxTasks = 64;
	localparam int IdxW     = $clog2(MaxTasks);
	localparam int CntW     = $clog2(MaxTasks + 1);
	localparam int EntryW   = 80;

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_DISPATCH = 2'd1,
		OP_CLEAR    = 2'd2,
		OP_NONE     = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_FULL     = 3'd1,
		ST_RAN      = 3'd2,
		ST_ALL_DONE = 3'd3,
		ST_IDLE_RUN = 3'd4
	} status_t;

	localparam logic CFG_RUN_PENALTY = 1'b0;
	localparam logic CFG_WAIT_CREDIT = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_RUN,
		S_AGE,
		S_DONE
	} state_t;

	// One table entry as it sits in memory.
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] arrival;
		logic [15:0] remaining;
		logic [15:0] priority_v;
		logic [15:0] slice;
	} entry_t;

	// Memory access request from the sequencer.
	typedef struct packed {
		logic            we;
		logic [IdxW-1:0] waddr;
		entry_t          wdata;
		logic [IdxW-1:0] raddr;
	} mem_req_t;

endpackage

[hdl/dpas_ram.sv]
// ----------------------------------------------------------------------------
// Task table memory
// One write port and one registered read port holding the task entries.
// ----------------------------------------------------------------------------
module dpas_ram (
	input  logic                     clk,
	input  dpas_pkg::mem_req_t       req,
	output dpas_pkg::entry_t         rdata
);
	import dpas_pkg::*;

	entry_t mem [MaxTasks];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

[hdl/dynamic_priority_aging_scheduler.sv]
// Each request is one start pulse; a load, clear or unused opcode goes through the done state.
// A dispatch over the N loaded tasks runs in two passes when a task is picked:
// one memory pass selects, one read-modify-write pass admits and ages the table.
// One request at a time: busy is high from acceptance until the result strobe.
// Reset empties the table and sets run_penalty to 3 and wait_credit to 1;
// the receiver cannot stall, and each result is shown for one cycle with done.
// ----------------------------------------------------------------------------
// Dynamic priority aging scheduler
// Task table in a synchronous memory with a sequencer that scans and ages it.
// ----------------------------------------------------------------------------
module dynamic_priority_aging_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [15:0] task_id,
	input  logic [15:0] arrival_time,
	input  logic [15:0] burst_time,
	input  logic [15:0] start_priority,
	input  logic [15:0] time_slice,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] sequence_number,
	output logic [15:0] run_id,
	output logic [31:0] start_time,
	output logic [31:0] stop_time,
	output logic [15:0] new_priority
);
	import dpas_pkg::*;

	state_t state_q, state_d;
	mem_req_t req;
	entry_t   rdata;

	logic [7:0]  penalty_q, credit_q;
	logic [MaxTasks-1:0] ready_q, fin_q;
	logic [CntW-1:0] count_q, fcount_q;
	logic [31:0] now_q, disp_q;
	logic [1:0]  op_q;
	logic [CntW-1:0] ptr_q;       // address issued
	logic        rv_q;            // read data valid this cycle
	logic [IdxW-1:0] raddr_s1;    // address of data now in rdata
	logic        any_ready_q, found_q;
	logic [IdxW-1:0] pick_q;
	entry_t      best_q;

	dpas_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

	assign busy = (state_q != S_IDLE);

	// Candidate comparison during the select pass.
	logic cand_ok, better;
	always_comb begin
		cand_ok = rv_q && !fin_q[raddr_s1] && (!any_ready_q || ready_q[raddr_s1]);
		if (any_ready_q) begin
			if (rdata.priority_v != best_q.priority_v)
				better = rdata.priority_v < best_q.priority_v;
			else if (rdata.arrival != best_q.arrival)
				better = rdata.arrival < best_q.arrival;
			else
				better = rdata.id < best_q.id;
		end else begin
			if (rdata.arrival != best_q.arrival)
				better = rdata.arrival < best_q.arrival;
			else if (rdata.priority_v != best_q.priority_v)
				better = rdata.priority_v < best_q.priority_v;
			else
				better = rdata.id < best_q.id;
		end
	end

	// Run arithmetic on the picked entry.
	logic [31:0] st_c, sp_c;
	logic [15:0] run_c, rem_c, np_c;
	logic [16:0] np_sum;
	always_comb begin
		st_c   = (now_q < {16'd0, best_q.arrival}) ? {16'd0, best_q.arrival} : now_q;
		run_c  = (best_q.slice < best_q.remaining) ? best_q.slice : best_q.remaining;
		sp_c   = st_c + {16'd0, run_c};
		rem_c  = best_q.remaining - run_c;
		np_sum = {1'b0, best_q.priority_v} + {9'd0, penalty_q};
		np_c   = np_sum[16] ? 16'hFFFF : np_sum[15:0];
	end

	// Aging of the entry read in the age pass.
	logic [IdxW-1:0] age_idx;
	logic becomes_ready, ages;
	entry_t aged;
	always_comb begin
		age_idx = raddr_s1;
		becomes_ready = !fin_q[age_idx] && ({16'd0, rdata.arrival} <= now_q);
		ages = (age_idx != pick_q) && (ready_q[age_idx] || becomes_ready)
			&& ({16'd0, rdata.arrival} < now_q);
		aged = rdata;
		aged.priority_v = (rdata.priority_v > {8'd0, credit_q})
			? rdata.priority_v - {8'd0, credit_q} : 16'd0;
	end

	logic scan_end;
	assign scan_end = (ptr_q >= count_q) && !rv_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) begin
				state_d = (opcode == OP_DISPATCH) ? S_SCAN : S_DONE;
			end
			S_SCAN: if (scan_end) begin
				state_d = found_q ? S_RUN : S_DONE;
			end
			S_RUN:  state_d = S_AGE;
			S_AGE:  if (scan_end) begin
				state_d = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory requests.
	always_comb begin
		req = '0;
		req.raddr = ptr_q[IdxW-1:0];
		case (state_q)
			S_IDLE: begin
				req.we    = start && (opcode == OP_LOAD) && (count_q < CntW'(MaxTasks));
				req.waddr = count_q[IdxW-1:0];
				req.wdata = '{task_id, arrival_time, burst_time, start_priority, time_slice};
			end
			S_RUN: begin
				req.we    = 1'b1;
				req.waddr = pick_q;
				req.wdata = best_q;
				req.wdata.remaining  = rem_c;
				req.wdata.priority_v = np_c;
			end
			S_AGE: begin
				req.we    = rv_q && ages;
				req.waddr = age_idx;
				req.wdata = aged;
			end
			default: req.we = 1'b0;
		endcase
	end

	// Control registers and outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			penalty_q <= 8'd3;
			credit_q <= 8'd1;
			ready_q <= '0;
			fin_q <= '0;
			count_q <= '0;
			fcount_q <= '0;
			now_q <= '0;
			disp_q <= '0;
			op_q <= '0;
			ptr_q <= '0;
			rv_q <= 1'b0;
			raddr_s1 <= '0;
			any_ready_q <= 1'b0;
			found_q <= 1'b0;
			pick_q <= '0;
			done <= 1'b0;
			status <= '0;
			sequence_number <= '0;
			run_id <= '0;
			start_time <= '0;
			stop_time <= '0;
			new_priority <= '0;
		end else begin
			state_q <= state_d;
			done <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_RUN_PENALTY) penalty_q <= cfg_data;
				else credit_q <= cfg_data;
			end
			raddr_s1 <= ptr_q[IdxW-1:0];
			case (state_q)
				S_IDLE: if (start) begin
					op_q <= opcode;
					ptr_q <= '0;
					rv_q <= 1'b0;
					found_q <= 1'b0;
					any_ready_q <= |(ready_q & ~fin_q);
					status <= ST_ACCEPTED;
					sequence_number <= '0;
					run_id <= '0;
					start_time <= '0;
					stop_time <= '0;
					new_priority <= '0;
					if (opcode == OP_LOAD) begin
						if (count_q < CntW'(MaxTasks)) begin
							ready_q[count_q[IdxW-1:0]] <= 1'b0;
							fin_q[count_q[IdxW-1:0]] <= 1'b0;
							count_q <= count_q + CntW'(1);
						end else begin
							status <= ST_FULL;
						end
					end else if (opcode == OP_CLEAR) begin
						ready_q <= '0;
						fin_q <= '0;
						count_q <= '0;
						fcount_q <= '0;
						now_q <= '0;
						disp_q <= '0;
					end
				end
				S_SCAN, S_AGE: begin
					rv_q <= ptr_q < count_q;
					if (ptr_q < count_q) ptr_q <= ptr_q + CntW'(1);
					if (state_q == S_SCAN && cand_ok && (!found_q || better)) begin
						found_q <= 1'b1;
						pick_q <= raddr_s1;
					end
					if (state_q == S_AGE && rv_q && becomes_ready) begin
						ready_q[age_idx] <= 1'b1;
					end
					if (state_q == S_SCAN && scan_end) begin
						ptr_q <= '0;
						if (!found_q) status <= ST_IDLE_RUN;
					end
				end
				S_RUN: begin
					disp_q <= disp_q + 32'd1;
					now_q <= sp_c;
					start_time <= st_c;
					stop_time <= sp_c;
					new_priority <= np_c;
					run_id <= best_q.id;
					sequence_number <= disp_q + 32'd1;
					if (rem_c != 16'd0) begin
						ready_q[pick_q] <= 1'b1;
					end else begin
						fin_q[pick_q] <= 1'b1;
						ready_q[pick_q] <= 1'b0;
						fcount_q <= fcount_q + CntW'(1);
					end
					ptr_q <= '0;
					rv_q <= 1'b0;
				end
				S_DONE: begin
					done <= 1'b1;
					if (op_q == OP_DISPATCH && found_q) begin
						status <= (fcount_q == count_q) ? ST_ALL_DONE : ST_RAN;
					end
				end
				default: ;
			endcase
		end
	end

	// Best entry payload tracks the pick during the select pass.
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && cand_ok && (!found_q || better)) begin
			best_q <= rdata;
		end
	end

endmodule

[hdl/dpas_checker.sv]
// ----------------------------------------------------------------------------
// Scheduler port checker
// Checks the request and result timing seen on the top level's ports.
// ----------------------------------------------------------------------------
module dpas_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic [31:0] sequence_number
);
	import dpas_pkg::*;

	// A request makes the block busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request not taken");

	// A result ends the request.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	// Status codes stay in range.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= ST_IDLE_RUN) else $error("bad status");

	// Results that ran no task carry no sequence number.
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_ACCEPTED || status == ST_FULL || status == ST_IDLE_RUN)
		|-> sequence_number == 32'd0) else $error("stray sequence number");
endmodule

bind dynamic_priority_aging_scheduler dpas_checker u_dpas_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .sequence_number(sequence_number)
);
